// ===== hw/rtl/scfd_pkg.sv =====
package scfd_pkg;

   // Default frame buffer depth (one more than the longest frame body)
   localparam int FRAME_DEPTH_DEF = 16;

   // Shared multiply/divide unit widths
   localparam int MUL_A_W  = 8;
   localparam int MUL_B_W  = 12;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_W    = 8;
   localparam int STEP_W   = $clog2(PROD_W + 1);

   // Angle and percent limits
   localparam logic [7:0] ANGLE_MAX   = 8'd180;
   localparam logic [6:0] PCT_MAX     = 7'd100;
   localparam logic [11:0] PCT_SCALE  = 12'd100;

   // Reset values of the configuration registers
   localparam logic [7:0]  HOME_ONE_RST  = 8'd175;
   localparam logic [7:0]  HOME_TWO_RST  = 8'd5;
   localparam logic [7:0]  GRIP_ONE_RST  = 8'd5;
   localparam logic [7:0]  GRIP_TWO_RST  = 8'd175;
   localparam logic [10:0] PULSE_MIN_RST = 11'd700;
   localparam logic [11:0] PULSE_MAX_RST = 12'd2300;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_HOME_ONE  = 3'd0;
   localparam logic [2:0] REG_HOME_TWO  = 3'd1;
   localparam logic [2:0] REG_GRIP_ONE  = 3'd2;
   localparam logic [2:0] REG_GRIP_TWO  = 3'd3;
   localparam logic [2:0] REG_PULSE_MIN = 3'd4;
   localparam logic [2:0] REG_PULSE_MAX = 3'd5;

   // Reply kinds and error codes
   localparam logic       REPLY_ACK = 1'b0;
   localparam logic       REPLY_ERR = 1'b1;
   localparam logic [1:0] ERR_ANGLE_ONE = 2'd0;
   localparam logic [1:0] ERR_ANGLE_TWO = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN   = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd3;
   localparam logic [1:0] ERR_NONE      = 2'd0;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_OPEN  = 8'h3C;
   localparam logic [7:0] CH_CLOSE = 8'h3E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LC    = 8'h63;
   localparam logic [7:0] CH_LF_CMD = 8'h66;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_LH    = 8'h68;
   localparam logic [7:0] CH_LO    = 8'h6F;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_WAIT,
      SEQ_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      JOB_PULSE_ONE,
      JOB_PULSE_TWO,
      JOB_GRIP_ONE,
      JOB_GRIP_TWO
   } job_type;

   // Request to the shared unit: quotient = (mul_a * mul_b) / divisor
   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mul_a;
      logic [MUL_B_W-1:0] mul_b;
      logic [DIV_W-1:0]   divisor;
   } arith_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } arith_rsp_type;

   function automatic logic [7:0] clamp_angle(input logic [7:0] a);
      return (a > ANGLE_MAX) ? ANGLE_MAX : a;
   endfunction

   // Magnitude of a 9-bit signed difference
   function automatic logic [7:0] abs9(input logic [8:0] x);
      logic [8:0] neg;
      neg = ~x + 9'd1;
      return x[8] ? neg[7:0] : x[7:0];
   endfunction

endpackage

// ===== hw/rtl/servo_command_frame_decoder.sv =====
// Servo command frame decoder.
// The req_ channel takes one received ASCII byte per item (req_rx_byte).
// CR, LF and space are dropped; '<' opens a frame, '>' closes it and runs
// the command held in it. Single bare command characters run outside frames.
// Each command gives one item on the rsp_ channel: ack or error, both servo
// angles, both pulse widths and the grip percent.
// A byte that gives no reply is taken without a stall and req_ready stays high.
// A byte that gives a reply keeps req_ready low while four
// jobs (two pulse widths, two grip percentages) run one after another on a
// single multiplier followed by a 20-step restoring divider, and until the
// result is loaded into the output register.
// If the receiver stalls, the finished reply waits in the output register.
// Bytes that give no reply are still taken meanwhile; the next reply waits
// in the sequencer, with req_ready low, until the output register frees.
// Reset clears the frame state, sets the servo angles to the home angles,
// and loads the configuration registers with their defaults.
// The APB-style port (psel, penable, pwrite, paddr, pwdata, prdata) holds
// six registers at byte addresses 0x00..0x14; write it only while idle.
module servo_command_frame_decoder #(
   parameter int FRAME_DEPTH = scfd_pkg::FRAME_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reply_kind,
   output logic [7:0]  rsp_acked_command,
   output logic [1:0]  rsp_error_code,
   output logic [7:0]  rsp_angle_one,
   output logic [7:0]  rsp_angle_two,
   output logic [11:0] rsp_pulse_one_us,
   output logic [11:0] rsp_pulse_two_us,
   output logic [6:0]  rsp_grip_level,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import scfd_pkg::*;

   localparam int FL_W  = $clog2(FRAME_DEPTH);
   localparam int CMP_W = (FL_W > 4) ? FL_W : 4;
   localparam logic [FL_W-1:0] FL_MAX = FL_W'(FRAME_DEPTH - 1);
   localparam logic [3:0] SLEN_MAX = 4'd15;

   // Configuration registers
   logic [7:0]  home_one_ff, home_two_ff, grip_one_ff, grip_two_ff;
   logic [10:0] pulse_min_ff;
   logic [11:0] pulse_max_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   // Frame and command state
   logic            inside_ff, inside_in;
   logic [FL_W-1:0] flen_ff, flen_in;
   logic [3:0]      slen_ff, slen_in;
   logic [7:0]      chars_ff [4];
   logic [7:0]      chars_in [4];
   logic [7:0]      angle_one_ff, angle_one_in;
   logic [7:0]      angle_two_ff, angle_two_in;

   // Sequencer
   seq_state_type state_ff, state_in;
   job_type       job_ff, job_in;
   logic          accept;
   logic          load_rsp;
   logic          arith_start;
   arith_req_type arith_req;
   arith_rsp_type arith_rsp;

   // Captured reply header and job results
   logic        kind_ff, kind_in;
   logic [7:0]  letter_ff, letter_in;
   logic [1:0]  code_ff, code_in;
   logic [11:0] pulse_one_ff, pulse_two_ff;
   logic [6:0]  pct_one_ff, pct_two_ff;

   // Output register
   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_letter_ff, rsp_angle_one_ff, rsp_angle_two_ff;
   logic [1:0]  rsp_code_ff;
   logic [11:0] rsp_pulse_one_ff, rsp_pulse_two_ff;
   logic [6:0]  rsp_grip_ff;

   // Byte decode
   logic       do_run, bare, too_long, has_reply;
   logic [3:0] run_len;
   logic [7:0] rc0;
   logic       run_reply, run_kind, set_one, set_two;
   logic [7:0] run_letter, set_one_val, set_two_val;
   logic [1:0] run_code;
   logic       is_a, is_b, digits_ok;
   logic [3:0] dig1, dig2, dig3;
   logic [9:0] dig_val;
   logic [7:0] c;

   // Shared-unit operands
   logic        pulse_down;
   logic [11:0] span;
   logic [8:0]  n_one, d_one, n_two, d_two;
   logic        pct_ok_one, pct_ok_two;
   logic [11:0] pulse_calc;
   logic [6:0]  pct_calc;
   logic        pct_ok_sel;
   logic [7:0]  grip_sum;

   // ---------------------------------------------------------------
   // Configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         home_one_ff  <= HOME_ONE_RST;
         home_two_ff  <= HOME_TWO_RST;
         grip_one_ff  <= GRIP_ONE_RST;
         grip_two_ff  <= GRIP_TWO_RST;
         pulse_min_ff <= PULSE_MIN_RST;
         pulse_max_ff <= PULSE_MAX_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HOME_ONE:  home_one_ff  <= pwdata[7:0];
            REG_HOME_TWO:  home_two_ff  <= pwdata[7:0];
            REG_GRIP_ONE:  grip_one_ff  <= pwdata[7:0];
            REG_GRIP_TWO:  grip_two_ff  <= pwdata[7:0];
            REG_PULSE_MIN: pulse_min_ff <= pwdata[10:0];
            REG_PULSE_MAX: pulse_max_ff <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_index)
         REG_HOME_ONE:  prdata = 32'(home_one_ff);
         REG_HOME_TWO:  prdata = 32'(home_two_ff);
         REG_GRIP_ONE:  prdata = 32'(grip_one_ff);
         REG_GRIP_TWO:  prdata = 32'(grip_two_ff);
         REG_PULSE_MIN: prdata = 32'(pulse_min_ff);
         REG_PULSE_MAX: prdata = 32'(pulse_max_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Frame tracking for one byte
   assign c = req_rx_byte;

   always_comb begin
      inside_in = inside_ff;
      flen_in   = flen_ff;
      slen_in   = slen_ff;
      chars_in  = chars_ff;
      do_run    = 1'b0;
      bare      = 1'b0;
      too_long  = 1'b0;
      if (c == CH_CR || c == CH_LF || c == CH_SP) begin
         // drop
      end else if (c == CH_OPEN) begin
         inside_in = 1'b1;
         flen_in   = '0;
         slen_in   = '0;
      end else if (c == CH_CLOSE) begin
         do_run    = inside_ff;
         inside_in = 1'b0;
         flen_in   = '0;
         slen_in   = '0;
      end else if (inside_ff) begin
         if (flen_ff < FL_MAX) begin
            if (c != CH_NUL && CMP_W'(slen_ff) == CMP_W'(flen_ff) &&
                slen_ff != SLEN_MAX) begin
               if (slen_ff < 4'd4) begin
                  chars_in[slen_ff[1:0]] = c;
               end
               slen_in = slen_ff + 4'd1;
            end
            flen_in = flen_ff + FL_W'(1);
         end else begin
            inside_in = 1'b0;
            flen_in   = '0;
            slen_in   = '0;
            too_long  = 1'b1;
         end
      end else if (c == CH_LG || c == CH_LF_CMD || c == CH_LH || c == CH_LO ||
                   c == CH_LC || c == CH_ONE || c == CH_TWO || c == CH_QUERY) begin
         bare        = 1'b1;
         do_run      = 1'b1;
         chars_in[0] = c;
      end
   end

   // Command interpretation
   assign run_len = bare ? 4'd1 : slen_ff;
   assign rc0     = bare ? c : chars_ff[0];
   assign is_a    = (rc0 == CH_UA) || (rc0 == CH_LA);
   assign is_b    = (rc0 == CH_UB) || (rc0 == CH_LB);
   assign digits_ok = (chars_ff[1] >= CH_ZERO) && (chars_ff[1] <= CH_NINE) &&
                      (chars_ff[2] >= CH_ZERO) && (chars_ff[2] <= CH_NINE) &&
                      (chars_ff[3] >= CH_ZERO) && (chars_ff[3] <= CH_NINE);
   assign dig1    = chars_ff[1][3:0];
   assign dig2    = chars_ff[2][3:0];
   assign dig3    = chars_ff[3][3:0];
   assign dig_val = 10'(dig1) * 10'd100 + 10'(dig2) * 10'd10 + 10'(dig3);

   always_comb begin
      run_reply   = 1'b1;
      run_kind    = REPLY_ERR;
      run_letter  = CH_NUL;
      run_code    = ERR_UNKNOWN;
      set_one     = 1'b0;
      set_two     = 1'b0;
      set_one_val = clamp_angle(grip_one_ff);
      set_two_val = clamp_angle(grip_two_ff);
      if (run_len == 4'd0) begin
         run_reply = 1'b0;
      end else if (run_len == 4'd1) begin
         case (rc0) inside
            CH_LG, CH_LC: begin
               run_kind   = REPLY_ACK;
               run_letter = rc0;
               run_code   = ERR_NONE;
               set_one    = 1'b1;
               set_two    = 1'b1;
            end
            CH_LF_CMD, CH_LH, CH_LO: begin
               run_kind    = REPLY_ACK;
               run_letter  = rc0;
               run_code    = ERR_NONE;
               set_one     = 1'b1;
               set_two     = 1'b1;
               set_one_val = clamp_angle(home_one_ff);
               set_two_val = clamp_angle(home_two_ff);
            end
            CH_ONE, CH_TWO, CH_QUERY: begin
               run_kind   = REPLY_ACK;
               run_letter = rc0;
               run_code   = ERR_NONE;
            end
            default: ;
         endcase
      end else if (run_len == 4'd4 && (is_a || is_b)) begin
         if (!digits_ok || dig_val > 10'(ANGLE_MAX)) begin
            run_code = is_a ? ERR_ANGLE_ONE : ERR_ANGLE_TWO;
         end else begin
            run_kind    = REPLY_ACK;
            run_code    = ERR_NONE;
            run_letter  = is_a ? CH_UA : CH_UB;
            set_one     = is_a;
            set_two     = is_b;
            set_one_val = dig_val[7:0];
            set_two_val = dig_val[7:0];
         end
      end
   end

   assign has_reply = too_long || (do_run && run_reply);
   assign kind_in   = too_long ? REPLY_ERR : run_kind;
   assign letter_in = too_long ? CH_NUL : run_letter;
   assign code_in   = too_long ? ERR_TOO_LONG : run_code;
   assign angle_one_in = (do_run && set_one) ? set_one_val : angle_one_ff;
   assign angle_two_in = (do_run && set_two) ? set_two_val : angle_two_ff;

   // ---------------------------------------------------------------
   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid && has_reply) begin
               state_in = SEQ_START;
               job_in   = JOB_PULSE_ONE;
            end
         end
         SEQ_START: state_in = SEQ_WAIT;
         SEQ_WAIT: begin
            if (arith_rsp.done) begin
               if (job_ff == JOB_GRIP_TWO) begin
                  state_in = SEQ_FINISH;
               end else begin
                  state_in = SEQ_START;
                  job_in   = job_type'(job_ff + 2'd1);
               end
            end
         end
         SEQ_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      load_rsp    = 1'b0;
      arith_start = 1'b0;
      unique case (state_ff)
         SEQ_IDLE:   req_ready   = 1'b1;
         SEQ_START:  arith_start = 1'b1;
         SEQ_WAIT:   ;
         SEQ_FINISH: load_rsp    = !rsp_valid_ff || rsp_ready;
         default:    ;
      endcase
   end

   assign accept = req_valid && req_ready;

   // Operands for the current job
   assign pulse_down = pulse_max_ff < {1'b0, pulse_min_ff};
   assign span       = pulse_down ? ({1'b0, pulse_min_ff} - pulse_max_ff)
                                  : (pulse_max_ff - {1'b0, pulse_min_ff});
   assign n_one = {1'b0, home_one_ff} - {1'b0, angle_one_ff};
   assign d_one = {1'b0, home_one_ff} - {1'b0, grip_one_ff};
   assign n_two = {1'b0, angle_two_ff} - {1'b0, home_two_ff};
   assign d_two = {1'b0, grip_two_ff} - {1'b0, home_two_ff};
   assign pct_ok_one = (d_one != '0) && (n_one != '0) && (n_one[8] == d_one[8]);
   assign pct_ok_two = (d_two != '0) && (n_two != '0) && (n_two[8] == d_two[8]);

   always_comb begin
      arith_req.start = arith_start;
      unique case (job_ff)
         JOB_PULSE_ONE: begin
            arith_req.mul_a   = angle_one_ff;
            arith_req.mul_b   = span;
            arith_req.divisor = ANGLE_MAX;
            pct_ok_sel        = 1'b0;
         end
         JOB_PULSE_TWO: begin
            arith_req.mul_a   = angle_two_ff;
            arith_req.mul_b   = span;
            arith_req.divisor = ANGLE_MAX;
            pct_ok_sel        = 1'b0;
         end
         JOB_GRIP_ONE: begin
            arith_req.mul_a   = abs9(n_one);
            arith_req.mul_b   = PCT_SCALE;
            arith_req.divisor = abs9(d_one);
            pct_ok_sel        = pct_ok_one;
         end
         default: begin
            arith_req.mul_a   = abs9(n_two);
            arith_req.mul_b   = PCT_SCALE;
            arith_req.divisor = abs9(d_two);
            pct_ok_sel        = pct_ok_two;
         end
      endcase
   end

   // Finish the job result: offset the pulse, clamp the percent
   assign pulse_calc = pulse_down ? ({1'b0, pulse_min_ff} - arith_rsp.quotient[11:0])
                                  : ({1'b0, pulse_min_ff} + arith_rsp.quotient[11:0]);
   assign pct_calc = !pct_ok_sel ? 7'd0 :
                     (arith_rsp.quotient > PROD_W'(PCT_MAX)) ? PCT_MAX :
                     arith_rsp.quotient[6:0];
   assign grip_sum = {1'b0, pct_one_ff} + {1'b0, pct_two_ff};

   scfd_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .arith_rsp (arith_rsp)
   );

   // ---------------------------------------------------------------
   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         job_ff       <= JOB_PULSE_ONE;
         inside_ff    <= 1'b0;
         flen_ff      <= '0;
         slen_ff      <= '0;
         angle_one_ff <= clamp_angle(HOME_ONE_RST);
         angle_two_ff <= clamp_angle(HOME_TWO_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         if (accept) begin
            inside_ff    <= inside_in;
            flen_ff      <= flen_in;
            slen_ff      <= slen_in;
            angle_one_ff <= angle_one_in;
            angle_two_ff <= angle_two_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         chars_ff  <= chars_in;
         kind_ff   <= kind_in;
         letter_ff <= letter_in;
         code_ff   <= code_in;
      end
      if (state_ff == SEQ_WAIT && arith_rsp.done) begin
         case (job_ff)
            JOB_PULSE_ONE: pulse_one_ff <= pulse_calc;
            JOB_PULSE_TWO: pulse_two_ff <= pulse_calc;
            JOB_GRIP_ONE:  pct_one_ff   <= pct_calc;
            default:       pct_two_ff   <= pct_calc;
         endcase
      end
      if (load_rsp) begin
         rsp_kind_ff      <= kind_ff;
         rsp_letter_ff    <= letter_ff;
         rsp_code_ff      <= code_ff;
         rsp_angle_one_ff <= angle_one_ff;
         rsp_angle_two_ff <= angle_two_ff;
         rsp_pulse_one_ff <= pulse_one_ff;
         rsp_pulse_two_ff <= pulse_two_ff;
         rsp_grip_ff      <= grip_sum[7:1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reply_kind    = rsp_kind_ff;
   assign rsp_acked_command = rsp_letter_ff;
   assign rsp_error_code    = rsp_code_ff;
   assign rsp_angle_one     = rsp_angle_one_ff;
   assign rsp_angle_two     = rsp_angle_two_ff;
   assign rsp_pulse_one_us  = rsp_pulse_one_ff;
   assign rsp_pulse_two_us  = rsp_pulse_two_ff;
   assign rsp_grip_level    = rsp_grip_ff;

endmodule

// ===== hw/rtl/scfd_arith.sv =====
module scfd_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  scfd_pkg::arith_req_type arith_req,
   output scfd_pkg::arith_rsp_type arith_rsp
);
   import scfd_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   count_ff, count_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_W+1:0]    trial;

   // One restoring division step per cycle after the product is loaded
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {1'b0, rem_ff, quo_ff[PROD_W-1]} - {2'b00, divisor_ff};
      if (arith_req.start) begin
         busy_in    = 1'b1;
         count_in   = STEP_W'(PROD_W);
         quo_in     = PROD_W'(arith_req.mul_a) * PROD_W'(arith_req.mul_b);
         rem_in     = '0;
         divisor_in = arith_req.divisor;
      end else if (busy_ff) begin
         if (!trial[DIV_W+1]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[PROD_W-1]};
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign arith_rsp.done     = done_ff;
   assign arith_rsp.quotient = quo_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import scfd_pkg::*;

   localparam int TEXT_MAX      = 15;
   localparam int BODY_MAX      = FRAME_DEPTH_DEF - 1;
   localparam int FULL_SWING    = 180;
   localparam int PCT_FULL      = 100;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 150;
   localparam int QUIET_LIMIT   = 4000;

   localparam logic [7:0] BARE_CMDS [8] =
      '{CH_LG, CH_LF_CMD, CH_LH, CH_LO, CH_LC, CH_ONE, CH_TWO, CH_QUERY};
   localparam logic [7:0] ANGLE_CMDS [4] = '{CH_UA, CH_LA, CH_UB, CH_LB};

   typedef struct {
      logic        kind;
      logic [7:0]  letter;
      logic [1:0]  code;
      logic [7:0]  angle_one;
      logic [7:0]  angle_two;
      logic [11:0] pulse_one;
      logic [11:0] pulse_two;
      logic [6:0]  grip;
   } servo_reply_type;

   // Tracks the decoder state, predicts replies and checks them in order
   class servo_reply_board;
      logic [7:0]   home_one, home_two, grip_one, grip_two;
      logic [10:0]  pulse_min;
      logic [11:0]  pulse_max;
      bit           framing;
      int           frame_len;
      int           text_len;
      logic [7:0]   cmd_chars [4];
      logic [7:0]   servo_one, servo_two;
      servo_reply_type replies_due [$];
      int           mismatches;

      function new();
         home_one   = HOME_ONE_RST;
         home_two   = HOME_TWO_RST;
         grip_one   = GRIP_ONE_RST;
         grip_two   = GRIP_TWO_RST;
         pulse_min  = PULSE_MIN_RST;
         pulse_max  = PULSE_MAX_RST;
         framing    = 1'b0;
         frame_len  = 0;
         text_len   = 0;
         servo_one  = limit_deg(home_one);
         servo_two  = limit_deg(home_two);
         mismatches = 0;
      endfunction

      function logic [7:0] limit_deg(logic [7:0] a);
         return (a > ANGLE_MAX) ? ANGLE_MAX : a;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_HOME_ONE:  home_one  = value[7:0];
            REG_HOME_TWO:  home_two  = value[7:0];
            REG_GRIP_ONE:  grip_one  = value[7:0];
            REG_GRIP_TWO:  grip_two  = value[7:0];
            REG_PULSE_MIN: pulse_min = value[10:0];
            REG_PULSE_MAX: pulse_max = value[11:0];
            default: ;
         endcase
      endfunction

      // Interpolate between the pulse limits; a reversed span runs downward
      function logic [11:0] pulse_width(logic [7:0] a);
         int ang, lo, hi, w;
         ang = int'(a);
         lo  = int'(pulse_min);
         hi  = int'(pulse_max);
         if (hi >= lo) w = lo + ang * (hi - lo) / FULL_SWING;
         else w = lo - ang * (lo - hi) / FULL_SWING;
         return w[11:0];
      endfunction

      function int clamp_pct(int p);
         if (p < 0) return 0;
         if (p > PCT_FULL) return PCT_FULL;
         return p;
      endfunction

      // Average of the per-servo grip shares, each zero on a zero divisor
      function logic [6:0] grip_now();
         int n1, d1, n2, d2, p1, p2, avg;
         n1 = int'(home_one) - int'(servo_one);
         d1 = int'(home_one) - int'(grip_one);
         n2 = int'(servo_two) - int'(home_two);
         d2 = int'(grip_two) - int'(home_two);
         p1 = (d1 != 0) ? (n1 * PCT_FULL) / d1 : 0;
         p2 = (d2 != 0) ? (n2 * PCT_FULL) / d2 : 0;
         avg = (clamp_pct(p1) + clamp_pct(p2)) / 2;
         return avg[6:0];
      endfunction

      function void push_reply(logic kind, logic [7:0] letter, logic [1:0] code);
         servo_reply_type r;
         r.kind      = kind;
         r.letter    = letter;
         r.code      = code;
         r.angle_one = servo_one;
         r.angle_two = servo_two;
         r.pulse_one = pulse_width(servo_one);
         r.pulse_two = pulse_width(servo_two);
         r.grip      = grip_now();
         replies_due.push_back(r);
      endfunction

      // Decode the held command text
      function void run_text();
         logic [7:0] c0, d;
         bit         is_a, is_b, ok;
         int         value;
         c0 = cmd_chars[0];
         if (text_len == 0) return;
         if (text_len == 1) begin
            if (c0 == CH_LG || c0 == CH_LC) begin
               servo_one = limit_deg(grip_one);
               servo_two = limit_deg(grip_two);
               push_reply(REPLY_ACK, c0, ERR_NONE);
            end else if (c0 == CH_LF_CMD || c0 == CH_LH || c0 == CH_LO) begin
               servo_one = limit_deg(home_one);
               servo_two = limit_deg(home_two);
               push_reply(REPLY_ACK, c0, ERR_NONE);
            end else if (c0 == CH_ONE || c0 == CH_TWO || c0 == CH_QUERY) begin
               push_reply(REPLY_ACK, c0, ERR_NONE);
            end else begin
               push_reply(REPLY_ERR, CH_NUL, ERR_UNKNOWN);
            end
            return;
         end
         is_a = (c0 == CH_UA || c0 == CH_LA);
         is_b = (c0 == CH_UB || c0 == CH_LB);
         if (text_len == 4 && (is_a || is_b)) begin
            value = 0;
            ok    = 1'b1;
            for (int i = 1; i < 4; i++) begin
               d = cmd_chars[i[1:0]];
               if (d < CH_ZERO || d > CH_NINE) ok = 1'b0;
               else value = value * 10 + int'(d - CH_ZERO);
            end
            if (!ok || value > FULL_SWING) begin
               push_reply(REPLY_ERR, CH_NUL, is_a ? ERR_ANGLE_ONE : ERR_ANGLE_TWO);
            end else begin
               if (is_a) servo_one = value[7:0];
               else servo_two = value[7:0];
               push_reply(REPLY_ACK, is_a ? CH_UA : CH_UB, ERR_NONE);
            end
            return;
         end
         push_reply(REPLY_ERR, CH_NUL, ERR_UNKNOWN);
      endfunction

      // Advance on one accepted byte; return 1 unless the byte is dropped
      function bit take_byte(logic [7:0] c);
         bit used;
         if (c == CH_CR || c == CH_LF || c == CH_SP) return 1'b0;
         if (c == CH_OPEN) begin
            framing   = 1'b1;
            frame_len = 0;
            text_len  = 0;
            return 1'b1;
         end
         if (c == CH_CLOSE) begin
            used = framing;
            if (framing) run_text();
            framing   = 1'b0;
            frame_len = 0;
            text_len  = 0;
            return used;
         end
         if (framing) begin
            if (frame_len < BODY_MAX) begin
               if (c != CH_NUL && text_len == frame_len && text_len < TEXT_MAX) begin
                  if (text_len < 4) cmd_chars[text_len[1:0]] = c;
                  text_len++;
               end
               frame_len++;
               return 1'b1;
            end
            // frame overflow: close it and drop the byte
            framing   = 1'b0;
            frame_len = 0;
            text_len  = 0;
            push_reply(REPLY_ERR, CH_NUL, ERR_TOO_LONG);
            return 1'b1;
         end
         foreach (BARE_CMDS[i]) begin
            if (c == BARE_CMDS[i]) begin
               cmd_chars[0] = c;
               text_len     = 1;
               run_text();
               text_len     = 0;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void same_field(string name, logic [11:0] want, logic [11:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(servo_reply_type got);
         servo_reply_type want;
         if (replies_due.size() == 0) begin
            $error("reply with none pending: kind %0d command %0d code %0d",
                   got.kind, got.letter, got.code);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         same_field("reply_kind", 12'(want.kind), 12'(got.kind));
         same_field("acked_command", 12'(want.letter), 12'(got.letter));
         same_field("error_code", 12'(want.code), 12'(got.code));
         same_field("angle_one", 12'(want.angle_one), 12'(got.angle_one));
         same_field("angle_two", 12'(want.angle_two), 12'(got.angle_two));
         same_field("pulse_one_us", want.pulse_one, got.pulse_one);
         same_field("pulse_two_us", want.pulse_two, got.pulse_two);
         same_field("grip_level", 12'(want.grip), 12'(got.grip));
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_reply_kind;
   logic [7:0]  rsp_acked_command;
   logic [1:0]  rsp_error_code;
   logic [7:0]  rsp_angle_one;
   logic [7:0]  rsp_angle_two;
   logic [11:0] rsp_pulse_one_us;
   logic [11:0] rsp_pulse_two_us;
   logic [6:0]  rsp_grip_level;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [4:0]  paddr       = 5'd0;
   logic [31:0] pwdata      = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   servo_reply_board board = new();
   servo_reply_type  seen_reply;
   logic [7:0]       frame_body [$];
   bit               idle_on = 1'b1;
   int               items_used = 0;
   int               rsp_stall = 0;
   int               quiet_cycles = 0;

   servo_command_frame_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reply_kind    (rsp_reply_kind),
      .rsp_acked_command (rsp_acked_command),
      .rsp_error_code    (rsp_error_code),
      .rsp_angle_one     (rsp_angle_one),
      .rsp_angle_two     (rsp_angle_two),
      .rsp_pulse_one_us  (rsp_pulse_one_us),
      .rsp_pulse_two_us  (rsp_pulse_two_us),
      .rsp_grip_level    (rsp_grip_level),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #1 clock = ~clock;

   // Check each delivered reply; stall the reply side in random bursts
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         seen_reply.kind      = rsp_reply_kind;
         seen_reply.letter    = rsp_acked_command;
         seen_reply.code      = rsp_error_code;
         seen_reply.angle_one = rsp_angle_one;
         seen_reply.angle_two = rsp_angle_two;
         seen_reply.pulse_one = rsp_pulse_one_us;
         seen_reply.pulse_two = rsp_pulse_two_us;
         seen_reply.grip      = rsp_grip_level;
         board.check_reply(seen_reply);
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // Offer one byte, with an optional gap first, and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      void'(board.take_byte(b));
      items_used++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] line_noise();
      case ($urandom_range(0, 2))
         0: return CH_CR;
         1: return CH_LF;
         default: return CH_SP;
      endcase
   endfunction

   // Any byte that keeps a frame open, zero fairly often
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      if ($urandom_range(0, 7) == 0) return CH_NUL;
      do b = 8'($urandom_range(0, 255)); while (b == CH_OPEN || b == CH_CLOSE);
      return b;
   endfunction

   // Wrap frame_body in a frame, with line noise and now and then no close
   task automatic send_frame();
      send_byte(CH_OPEN);
      foreach (frame_body[i]) begin
         if ($urandom_range(0, 24) == 0) send_byte(line_noise());
         send_byte(frame_body[i]);
      end
      if ($urandom_range(0, 29) != 0) send_byte(CH_CLOSE);
   endtask

   task automatic send_message();
      int         pick, value;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      frame_body.delete();
      if (pick < 35) begin
         // angle command, mostly in range, sometimes a bad digit or length
         value = ($urandom_range(0, 7) == 0) ? $urandom_range(181, 999)
                                             : $urandom_range(0, FULL_SWING);
         frame_body.push_back(ANGLE_CMDS[2'($urandom_range(0, 3))]);
         b = 8'(CH_ZERO + value / 100);
         frame_body.push_back(b);
         b = 8'(CH_ZERO + (value / 10) % 10);
         frame_body.push_back(b);
         b = 8'(CH_ZERO + value % 10);
         frame_body.push_back(b);
         if ($urandom_range(0, 11) == 0) frame_body[$urandom_range(1, 3)] = body_byte();
         if ($urandom_range(0, 15) == 0) begin
            b = 8'(CH_ZERO + $urandom_range(0, 9));
            frame_body.push_back(b);
         end else if ($urandom_range(0, 15) == 0) begin
            frame_body.delete(frame_body.size() - 1);
         end
         send_frame();
      end else if (pick < 55) begin
         frame_body.push_back(($urandom_range(0, 4) != 0)
                              ? BARE_CMDS[3'($urandom_range(0, 7))] : body_byte());
         send_frame();
      end else if (pick < 70) begin
         send_byte(($urandom_range(0, 3) != 0) ? BARE_CMDS[3'($urandom_range(0, 7))]
                                               : body_byte());
      end else if (pick < 85) begin
         // random body, long enough at times to overflow the frame
         repeat ($urandom_range(0, 20)) frame_body.push_back(body_byte());
         send_frame();
      end else if (pick < 93) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 1) == 1) begin
         // abandon a partial frame by opening a new one
         send_byte(CH_OPEN);
         repeat ($urandom_range(0, 5)) send_byte(body_byte());
         frame_body.push_back(BARE_CMDS[3'($urandom_range(0, 7))]);
         send_frame();
      end else begin
         send_byte(CH_CLOSE);
      end
   endtask

   // Write one register: setup cycle, access cycle, then release the bus
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int phase);
      logic [7:0]  h1, h2, g1, g2;
      logic [10:0] lo;
      logic [11:0] hi;
      case (phase)
         1: begin
            h1 = 8'd180; h2 = 8'd0; g1 = 8'd0; g2 = 8'd180;
            lo = 11'd500; hi = 12'd2500;
         end
         2: begin
            // equal home and grip angles: zero divisors, clamped angles
            h1 = 8'd255; h2 = 8'd255; g1 = 8'd255; g2 = 8'd255;
            lo = 11'd1500; hi = 12'd1500;
         end
         3: begin
            // reversed pulse span, inverted grip directions
            h1 = 8'd10; h2 = 8'd170; g1 = 8'd170; g2 = 8'd10;
            lo = 11'd2047; hi = 12'd0;
         end
         4: begin
            h1 = 8'd255; h2 = 8'd0; g1 = 8'd0; g2 = 8'd255;
            lo = 11'd0; hi = 12'd4095;
         end
         default: begin
            h1 = 8'($urandom_range(0, FULL_SWING));
            h2 = 8'($urandom_range(0, FULL_SWING));
            g1 = 8'($urandom_range(0, FULL_SWING));
            g2 = 8'($urandom_range(0, FULL_SWING));
            lo = 11'($urandom_range(500, 1500));
            hi = 12'($urandom_range(1500, 2500));
         end
      endcase
      csr_write(REG_HOME_ONE, 32'(h1));
      csr_write(REG_HOME_TWO, 32'(h2));
      csr_write(REG_GRIP_ONE, 32'(g1));
      csr_write(REG_GRIP_TWO, 32'(g2));
      csr_write(REG_PULSE_MIN, 32'(lo));
      csr_write(REG_PULSE_MAX, 32'(hi));
   endtask

   // Stop offering bytes, collect all replies and let the block go idle
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.replies_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bare commands, angle frames, empty and broken frames
      send_byte(CH_LG);
      send_byte(CH_LF_CMD);
      send_byte(CH_QUERY);
      send_text("<A180>");
      send_text("<b0x5>");
      send_text("<>");
      send_byte(CH_CLOSE);
      send_text("<<g>");
      send_byte(CH_OPEN);
      send_byte(CH_NUL);
      send_byte(CH_LH);
      send_byte(CH_CLOSE);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_SP);
      send_byte(8'hFF);

      // Random phases, each under a fresh register setting
      for (int phase = 1; phase <= PHASES; phase++) begin
         drain_replies();
         apply_setting(phase);
         idle_on = (phase != 4 && phase != PHASES);
         phase_start = items_used;
         while (items_used - phase_start < PHASE_ITEMS) send_message();
      end
      drain_replies();

      if (board.mismatches == 0 && board.replies_due.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
